/* hdl/fica_pkg.sv */
`timescale 1ns / 1ps

package fica_pkg;

	localparam int CFG_W           = 21;
	localparam int CNT_W           = CFG_W + 1;
	localparam int OFF_W           = 20;
	localparam int QUAD_BYTES      = 16;
	localparam int DEF_STAGE_BYTES = 16;
	localparam int DEF_BANK_BYTES  = 1048576;
	localparam logic [CFG_W-1:0] MAX_IMAGE_RESET = 21'h100000;
	localparam logic [7:0] PAD_BYTE = 8'hFF;

	typedef enum logic [2:0] {
		OP_BEGIN    = 3'd0,
		OP_HEADER   = 3'd1,
		OP_DATA     = 3'd2,
		OP_COMMIT   = 3'd3,
		OP_ABORT    = 3'd4,
		OP_ACTIVATE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		KIND_REPLY = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_SWAP  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_READY = 3'd1,
		ST_TOO_BIG   = 3'd2,
		ST_BAD_SEQ   = 3'd3,
		ST_FLASH_ERR = 3'd4,
		ST_HASH_ERR  = 3'd5
	} status_t;

	typedef struct packed {
		op_t         operation;
		logic [31:0] image_length;
		logic [31:0] chunk_offset;
		logic [7:0]  data_byte;
		logic        chunk_last;
		logic        flash_fail;
		logic        digest_match;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		status_t          status;
		logic [CFG_W-1:0] ack_cursor;
		logic [OFF_W-1:0] write_offset;
		logic [63:0]      write_low;
		logic [63:0]      write_high;
		logic             last;
	} result_t;

	// Results of one item: count is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} step_t;

	function automatic result_t mk_reply(status_t s);
		result_t r;
		r        = '0;
		r.kind   = KIND_REPLY;
		r.status = s;
		return r;
	endfunction

endpackage

/* hdl/fica_core.sv */
`timescale 1ns / 1ps

module fica_core #(
	parameter int STAGE_BYTES = fica_pkg::DEF_STAGE_BYTES,
	parameter int BANK_BYTES  = fica_pkg::DEF_BANK_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fica_pkg::CFG_W-1:0] cfg_data,
	input  logic                       go,
	input  fica_pkg::item_t            item,
	output fica_pkg::step_t            step
);

	localparam int CW   = fica_pkg::CFG_W;
	localparam int NW   = fica_pkg::CNT_W;
	localparam int OW   = fica_pkg::OFF_W;
	localparam int QB   = fica_pkg::QUAD_BYTES;
	localparam int SC_W = $clog2(STAGE_BYTES + 1);
	localparam int SI_W = $clog2(STAGE_BYTES);
	localparam int NOUT = (STAGE_BYTES < QB) ? STAGE_BYTES : QB;
	localparam logic [SC_W-1:0] STAGE_FULL = SC_W'(STAGE_BYTES);

	logic [CW-1:0]   max_q;
	logic            sess_q, ver_q, open_q;
	logic [CW-1:0]   img_q;
	logic [NW-1:0]   prog_q;
	logic [SC_W-1:0] cnt_q;
	logic [7:0]      buf_q [STAGE_BYTES];

	logic            sess_d, ver_d, open_d;
	logic [CW-1:0]   img_d;
	logic [NW-1:0]   prog_d;
	logic [SC_W-1:0] cnt_d, cnt_inc;
	logic [7:0]      buf_d [STAGE_BYTES];

	logic [CW-1:0]   limit;
	logic [NW-1:0]   cursor, cursor_new;
	logic            emit_wr, emit_rep, emit_swap, dead;
	fica_pkg::status_t rep_status;
	fica_pkg::result_t rep_r, wr_r, swap_r;
	logic [8*QB-1:0] quad;

	assign limit = (32'(max_q) < 32'(BANK_BYTES)) ? max_q : CW'(BANK_BYTES);
	assign cursor = prog_q + NW'(cnt_q);
	assign cnt_inc = cnt_q + SC_W'(1);

	always_comb begin
		sess_d     = sess_q;
		ver_d      = ver_q;
		open_d     = open_q;
		img_d      = img_q;
		prog_d     = prog_q;
		cnt_d      = cnt_q;
		buf_d      = buf_q;
		emit_wr    = 1'b0;
		emit_rep   = 1'b0;
		emit_swap  = 1'b0;
		dead       = 1'b0;
		rep_status = fica_pkg::ST_OK;

		unique case (item.operation)
			fica_pkg::OP_BEGIN: begin
				emit_rep = 1'b1;
				if (item.image_length == 32'd0 || item.image_length > 32'(limit)) begin
					rep_status = fica_pkg::ST_TOO_BIG;
				end else if (item.flash_fail) begin
					sess_d     = 1'b0;
					ver_d      = 1'b0;
					open_d     = 1'b0;
					rep_status = fica_pkg::ST_FLASH_ERR;
				end else begin
					sess_d = 1'b1;
					ver_d  = 1'b0;
					open_d = 1'b0;
					img_d  = item.image_length[CW-1:0];
					prog_d = '0;
					cnt_d  = '0;
				end
			end
			fica_pkg::OP_HEADER: begin
				open_d = 1'b0;
				if (!sess_q) begin
					emit_rep   = 1'b1;
					rep_status = fica_pkg::ST_NOT_READY;
				end else if (item.chunk_offset < 32'(cursor)) begin
					// Duplicate chunk: acknowledge the cursor again and drop it.
					emit_rep = 1'b1;
				end else if (item.chunk_offset > 32'(cursor)) begin
					emit_rep   = 1'b1;
					rep_status = fica_pkg::ST_BAD_SEQ;
				end else begin
					open_d = 1'b1;
				end
			end
			fica_pkg::OP_DATA: begin
				if (open_q && sess_q) begin
					// Bytes beyond the declared length are dropped silently.
					if (cursor < NW'(img_q) && cnt_q < STAGE_FULL) begin
						buf_d[cnt_q[SI_W-1:0]] = item.data_byte;
						cnt_d = cnt_inc;
						if (cnt_inc == STAGE_FULL) begin
							emit_wr = 1'b1;
							cnt_d   = '0;
							if (item.flash_fail) begin
								sess_d     = 1'b0;
								ver_d      = 1'b0;
								open_d     = 1'b0;
								emit_rep   = 1'b1;
								rep_status = fica_pkg::ST_FLASH_ERR;
								dead       = 1'b1;
							end else begin
								prog_d = prog_q + NW'(STAGE_BYTES);
							end
						end
					end
					if (!dead && item.chunk_last) begin
						emit_rep = 1'b1;
						open_d   = 1'b0;
					end
				end
			end
			fica_pkg::OP_COMMIT: begin
				open_d   = 1'b0;
				emit_rep = 1'b1;
				if (!sess_q) begin
					rep_status = fica_pkg::ST_NOT_READY;
				end else begin
					if (cnt_q != '0) begin
						for (int i = 0; i < STAGE_BYTES; i++) begin
							if (SC_W'(i) >= cnt_q) begin
								buf_d[i] = fica_pkg::PAD_BYTE;
							end
						end
						emit_wr = 1'b1;
						cnt_d   = '0;
						if (item.flash_fail) begin
							sess_d     = 1'b0;
							ver_d      = 1'b0;
							rep_status = fica_pkg::ST_FLASH_ERR;
							dead       = 1'b1;
						end else begin
							prog_d = prog_q + NW'(STAGE_BYTES);
						end
					end
					if (!dead) begin
						if (prog_d < NW'(img_q)) begin
							rep_status = fica_pkg::ST_BAD_SEQ;
						end else if (!item.digest_match) begin
							sess_d     = 1'b0;
							ver_d      = 1'b0;
							rep_status = fica_pkg::ST_HASH_ERR;
						end else begin
							ver_d = 1'b1;
						end
					end
				end
			end
			fica_pkg::OP_ABORT: begin
				sess_d   = 1'b0;
				ver_d    = 1'b0;
				open_d   = 1'b0;
				cnt_d    = '0;
				emit_rep = 1'b1;
			end
			fica_pkg::OP_ACTIVATE: begin
				if (ver_q) begin
					sess_d    = 1'b0;
					ver_d     = 1'b0;
					open_d    = 1'b0;
					emit_swap = 1'b1;
				end else begin
					emit_rep   = 1'b1;
					rep_status = fica_pkg::ST_NOT_READY;
				end
			end
			default: begin
			end
		endcase
	end

	// Every reply reports the cursor as it stands after the item.
	assign cursor_new = prog_d + NW'(cnt_d);

	always_comb begin
		quad = '0;
		for (int i = 0; i < NOUT; i++) begin
			quad[i*8 +: 8] = buf_d[i];
		end
	end

	always_comb begin
		rep_r            = fica_pkg::mk_reply(rep_status);
		rep_r.ack_cursor = cursor_new[CW-1:0];

		wr_r              = '0;
		wr_r.kind         = fica_pkg::KIND_WRITE;
		wr_r.write_offset = prog_q[OW-1:0];
		wr_r.write_low    = quad[63:0];
		wr_r.write_high   = quad[127:64];

		swap_r      = '0;
		swap_r.kind = fica_pkg::KIND_SWAP;

		step = '0;
		if (emit_swap) begin
			step.count = 2'd1;
			step.first = swap_r;
		end else if (emit_wr) begin
			step.first = wr_r;
			if (emit_rep) begin
				step.count  = 2'd2;
				step.second = rep_r;
			end else begin
				step.count = 2'd1;
			end
		end else if (emit_rep) begin
			step.count = 2'd1;
			step.first = rep_r;
		end

		if (step.count == 2'd2) begin
			step.second.last = 1'b1;
		end else if (step.count == 2'd1) begin
			step.first.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= fica_pkg::MAX_IMAGE_RESET;
			sess_q <= 1'b0;
			ver_q  <= 1'b0;
			open_q <= 1'b0;
			img_q  <= '0;
			prog_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (go) begin
				sess_q <= sess_d;
				ver_q  <= ver_d;
				open_q <= open_d;
				img_q  <= img_d;
				prog_q <= prog_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			buf_q <= buf_d;
		end
	end

endmodule

/* hdl/fica_out_buf.sv */
`timescale 1ns / 1ps

module fica_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fica_pkg::step_t   step,
	output logic              free,
	output logic              valid,
	input  logic              stall,
	output fica_pkg::result_t result
);

	logic [1:0]        cnt_q;
	fica_pkg::result_t head_q, tail_q;
	logic              pop;

	assign valid  = (cnt_q != 2'd0);
	assign result = head_q;
	assign pop    = valid && !stall;
	// A new item may load when no beat is held or the last held beat leaves in this cycle.
	assign free   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= step.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= step.first;
			tail_q <= step.second;
		end else if (pop && cnt_q == 2'd2) begin
			head_q <= tail_q;
		end
	end

endmodule

/* hdl/firmware_image_chunk_assembler.sv */
`timescale 1ns / 1ps

// Firmware image chunk assembler. Takes one command beat per cycle unless the
// input stalls (begin, chunk header, data byte, commit, abort, activate) and
// answers with status replies, 16-byte flash write beats and a bank swap
// request. A beat passes through an input register, is decided against the
// session state, and its result beats are loaded into the result register. An
// item yields at most two result beats; the result register shows one beat per
// cycle unless the result side stalls, so a two-beat item holds the input until
// its second beat leaves, and any other item sustains one item per cycle. The
// max image length register is written via the cfg channel, which is always ready.
module firmware_image_chunk_assembler #(
	parameter int STAGE_BYTES = fica_pkg::DEF_STAGE_BYTES,
	parameter int BANK_BYTES  = fica_pkg::DEF_BANK_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  fica_pkg::item_t            item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output fica_pkg::result_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [fica_pkg::CFG_W-1:0] cfg_data
);

	logic            valid_s1;
	fica_pkg::item_t item_s1;
	logic            free;
	logic            go;
	fica_pkg::step_t step;

	assign cfg_ready  = 1'b1;
	assign go         = valid_s1 && free;
	assign item_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	fica_core #(
		.STAGE_BYTES(STAGE_BYTES),
		.BANK_BYTES (BANK_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.go      (go),
		.item    (item_s1),
		.step    (step)
	);

	fica_out_buf u_out_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (go),
		.step  (step),
		.free  (free),
		.valid (result_valid),
		.stall (result_stall),
		.result(result)
	);

`ifndef SYNTH
	// Only the final beat of an item carries last.
	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		go && step.count == 2'd2 |-> !step.first.last && step.second.last)
		else $error("two-beat item has wrong last marking");

	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		go && step.count == 2'd1 |-> step.first.last)
		else $error("single-beat item lacks last");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_swap_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == fica_pkg::KIND_SWAP |->
			result.ack_cursor == '0 && result.last)
		else $error("bank swap beat carries stray fields");
`endif

endmodule
